>>> design/pad_link_command_responder_unit_assert.svh
// Assertion macros shared by the link responder modules.
`ifndef PAD_LINK_COMMAND_RESPONDER_UNIT_ASSERT_SVH
`define PAD_LINK_COMMAND_RESPONDER_UNIT_ASSERT_SVH

// Expression must hold at every edge outside reset.
`define PLCR_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLCR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/plcr_pkg.sv
`timescale 1ns / 1ps

package plcr_pkg;

   // Sizes and reset values
   localparam int CARD_BITS_DEF = 256;
   localparam int QUEUE_DEPTH   = 2;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 8;

   localparam logic [7:0] IDLE_FLIP_RESET  = 8'd35;
   localparam logic [7:0] DISCONNECT_RESET = 8'd100;

   // Card data CRC
   localparam logic [7:0] CRC_SEED  = 8'hFF;
   localparam logic [7:0] CRC_TERM0 = 8'h8F;
   localparam logic [7:0] CRC_POLY  = 8'hC2;

   // Command bytes
   localparam logic [7:0] CMD_ORIGIN_A   = 8'h41;
   localparam logic [7:0] CMD_ORIGIN_B   = 8'h42;
   localparam logic [7:0] CMD_POLL_B     = 8'h40;
   localparam logic [7:0] CMD_POLL_A     = 8'h01;
   localparam logic [7:0] CMD_CARD_READ  = 8'h02;
   localparam logic [7:0] CMD_CARD_WRITE = 8'h03;

   // Item kinds
   localparam logic [1:0] KIND_CMD  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   // Reply codes
   localparam logic [2:0] REPLY_NONE      = 3'd0;
   localparam logic [2:0] REPLY_STATUS_A  = 3'd1;
   localparam logic [2:0] REPLY_STATUS_B  = 3'd2;
   localparam logic [2:0] REPLY_ORIGIN    = 3'd3;
   localparam logic [2:0] REPLY_POLL_B    = 3'd4;
   localparam logic [2:0] REPLY_POLL_A    = 3'd5;
   localparam logic [2:0] REPLY_CARD_READ = 3'd6;
   localparam logic [2:0] REPLY_CARD_CRC  = 3'd7;

   // Event codes
   localparam logic [2:0] EVENT_NONE       = 3'd0;
   localparam logic [2:0] EVENT_DETECT_B   = 3'd1;
   localparam logic [2:0] EVENT_DETECT_A   = 3'd2;
   localparam logic [2:0] EVENT_DISCONNECT = 3'd3;
   localparam logic [2:0] EVENT_FLIP       = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_FLIP  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCONNECT = 1'b1;

   typedef enum logic [1:0] {
      LINK_IDLE = 2'd0,
      LINK_B    = 2'd1,
      LINK_A    = 2'd2
   } link_type;

   // Classified operation handed from front to back
   typedef enum logic [3:0] {
      OP_NONE,
      OP_STATUS,
      OP_ORIGIN,
      OP_POLL_B,
      OP_POLL_A,
      OP_CARD_READ,
      OP_ARM,
      OP_DATA,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type op;
      logic   data_bit;
   } op_item_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] cmd_byte;
      logic       data_bit;
   } req_type;

   typedef struct packed {
      logic [2:0] reply;
      logic [7:0] crc_value;
      logic [2:0] event_res;
      logic       mode_a_enabled;
   } rsp_type;

   typedef struct packed {
      logic [7:0] idle_flip_ticks;
      logic [7:0] disconnect_ticks;
   } cfg_type;

endpackage

>>> design/plcr_fifo.sv
`timescale 1ns / 1ps
`include "pad_link_command_responder_unit_assert.svh"

module plcr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   `PLCR_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH),
      "queue count beyond depth")
   `PLCR_ASSERT_NEXT(a_push_not_empty, clock, reset, do_push && !do_pop, !empty,
      "queue empty after a beat was written")
   `PLCR_ASSERT_NEXT(a_ptr_gap, clock, reset, full,
      wr_ptr_ff == rd_ptr_ff || !full, "full queue with unequal pointers")

endmodule

>>> design/plcr_front.sv
`timescale 1ns / 1ps

module plcr_front
   import plcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_data,
   output logic        full,
   output op_item_type op_item,
   output logic        op_valid,
   input  logic        op_pop
);

   op_item_type dec_item;
   logic [$bits(op_item_type)-1:0] op_raw;
   logic        op_empty;

   // classify the incoming beat
   always_comb begin
      dec_item.data_bit = req_data.data_bit;
      dec_item.op       = OP_NONE;
      case (req_data.command)
         KIND_CMD: begin
            case (req_data.cmd_byte)
               CMD_ORIGIN_A, CMD_ORIGIN_B: dec_item.op = OP_ORIGIN;
               CMD_POLL_B:                 dec_item.op = OP_POLL_B;
               CMD_POLL_A:                 dec_item.op = OP_POLL_A;
               CMD_CARD_READ:              dec_item.op = OP_CARD_READ;
               CMD_CARD_WRITE:             dec_item.op = OP_ARM;
               default:                    dec_item.op = OP_STATUS;
            endcase
         end
         KIND_DATA: dec_item.op = OP_DATA;
         KIND_TICK: dec_item.op = OP_TICK;
         default:   dec_item.op = OP_NONE;
      endcase
   end

   // operation queue toward the back end
   plcr_fifo #(
      .WIDTH ($bits(op_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_op_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (dec_item),
      .full  (full),
      .pop   (op_pop),
      .rdata (op_raw),
      .empty (op_empty)
   );

   assign op_item  = op_item_type'(op_raw);
   assign op_valid = !op_empty;

endmodule

>>> design/plcr_back.sv
`timescale 1ns / 1ps
`include "pad_link_command_responder_unit_assert.svh"

module plcr_back
   import plcr_pkg::*;
#(
   parameter int CARD_BITS = CARD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  op_item_type op_item,
   input  logic        op_valid,
   output logic        op_pop,
   output rsp_type     rsp_data,
   output logic        empty,
   input  logic        pop
);

   localparam int CNT_W = $clog2(CARD_BITS + 1);

   logic             mode_a_ff, mode_a_in;
   link_type         link_ff, link_in;
   link_type         seen_ff, seen_in;
   logic [7:0]       tick_ff, tick_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       term_ff, term_in;
   logic [CNT_W-1:0] bitpos_ff, bitpos_in;
   logic             armed_ff, armed_in;

   logic             res_full, op_fire;
   rsp_type          res;
   logic [$bits(rsp_type)-1:0] res_raw;
   logic [7:0]       tick_inc, idle_lim, disc_lim, term_next;
   logic [CNT_W-1:0] bitpos_inc;

   assign op_fire    = op_valid && !res_full;
   assign op_pop     = op_fire;
   assign tick_inc   = (tick_ff == 8'hFF) ? tick_ff : tick_ff + 8'd1;
   assign idle_lim   = (cfg.idle_flip_ticks == 8'd0) ? 8'd1 : cfg.idle_flip_ticks;
   assign disc_lim   = (cfg.disconnect_ticks == 8'd0) ? 8'd1 : cfg.disconnect_ticks;
   assign term_next  = {1'b0, term_ff[7:1]} ^ (term_ff[0] ? CRC_POLY : 8'h00);
   assign bitpos_inc = bitpos_ff + 1'b1;

   // one operation per cycle while the result queue has room
   always_comb begin
      mode_a_in = mode_a_ff;
      link_in   = link_ff;
      seen_in   = seen_ff;
      tick_in   = tick_ff;
      crc_in    = crc_ff;
      term_in   = term_ff;
      bitpos_in = bitpos_ff;
      armed_in  = armed_ff;
      res       = '0;
      if (op_fire) begin
         case (op_item.op)
            OP_STATUS: res.reply = mode_a_ff ? REPLY_STATUS_A : REPLY_STATUS_B;
            OP_ORIGIN: res.reply = REPLY_ORIGIN;
            OP_POLL_B: begin
               tick_in   = '0;
               link_in   = LINK_B;
               res.reply = REPLY_POLL_B;
            end
            OP_POLL_A: begin
               tick_in   = '0;
               link_in   = LINK_A;
               res.reply = REPLY_POLL_A;
            end
            OP_CARD_READ: res.reply = REPLY_CARD_READ;
            OP_ARM: begin
               crc_in    = CRC_SEED;
               term_in   = CRC_TERM0;
               bitpos_in = '0;
               armed_in  = 1'b1;
            end
            OP_DATA: begin
               if (armed_ff) begin
                  if (op_item.data_bit) begin
                     crc_in = crc_ff ^ term_ff;
                  end
                  term_in   = term_next;
                  bitpos_in = bitpos_inc;
                  // last card bit: report CRC and disarm
                  if (bitpos_inc == CNT_W'(CARD_BITS)) begin
                     res.reply     = REPLY_CARD_CRC;
                     res.crc_value = crc_in;
                     armed_in      = 1'b0;
                     bitpos_in     = '0;
                  end
               end
            end
            OP_TICK: begin
               tick_in = tick_inc;
               // mode change seen by the watchdog
               if (link_ff != seen_ff) begin
                  tick_in = '0;
                  seen_in = link_ff;
                  if (link_ff == LINK_B) begin
                     res.event_res = EVENT_DETECT_B;
                  end else if (link_ff == LINK_A) begin
                     res.event_res = EVENT_DETECT_A;
                  end
               end
               if (seen_in == LINK_IDLE) begin
                  if (tick_in >= idle_lim) begin
                     tick_in       = '0;
                     mode_a_in     = !mode_a_ff;
                     res.event_res = EVENT_FLIP;
                  end
               end else if (tick_in >= disc_lim) begin
                  tick_in       = '0;
                  res.event_res = EVENT_DISCONNECT;
               end
            end
            default: ;
         endcase
      end
      res.mode_a_enabled = mode_a_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_a_ff <= 1'b1;
         link_ff   <= LINK_IDLE;
         seen_ff   <= LINK_IDLE;
         tick_ff   <= '0;
         crc_ff    <= CRC_SEED;
         term_ff   <= CRC_TERM0;
         bitpos_ff <= '0;
         armed_ff  <= 1'b0;
      end else begin
         mode_a_ff <= mode_a_in;
         link_ff   <= link_in;
         seen_ff   <= seen_in;
         tick_ff   <= tick_in;
         crc_ff    <= crc_in;
         term_ff   <= term_in;
         bitpos_ff <= bitpos_in;
         armed_ff  <= armed_in;
      end
   end

   // result queue toward the consumer
   plcr_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (op_fire),
      .wdata (res),
      .full  (res_full),
      .pop   (pop),
      .rdata (res_raw),
      .empty (empty)
   );

   assign rsp_data = rsp_type'(res_raw);

   `PLCR_ASSERT_ALWAYS(a_idle_bitpos, clock, reset, armed_ff || bitpos_ff == '0,
      "bit position moved while CRC disarmed")
   `PLCR_ASSERT_NEXT(a_crc_done, clock, reset,
      op_fire && res.reply == REPLY_CARD_CRC, !armed_ff && bitpos_ff == '0,
      "CRC still armed after its reply")
   `PLCR_ASSERT_NEXT(a_flip, clock, reset,
      op_fire && res.event_res == EVENT_FLIP,
      tick_ff == 8'd0 && mode_a_ff != $past(mode_a_ff),
      "mode flip event without a flip")

endmodule

>>> design/pad_link_command_responder_unit.sv
`timescale 1ns / 1ps
// Game-pad side responder of a one-wire console link. Every accepted input
// beat (command byte, card write data bit or watchdog tick) yields exactly one
// result beat, in order. The block sustains one beat per clock on both sides
// while the consumer pops: a decode stage writes classified operations into a
// two-entry queue, and the execution stage updates the link state and CRC
// once per cycle, when there is room, into a two-entry result queue. The card
// write CRC is advanced one data bit per beat with a running term register,
// so its cost does not depend on CARD_BITS. The user must write the two limit
// registers through the csr port while no beat is in flight; the block does
// not enforce this. A limit of zero behaves as one.

module pad_link_command_responder_unit
   import plcr_pkg::*;
#(
   parameter int CARD_BITS = CARD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  req_type               req_data,
   output logic                  full,
   output rsp_type               rsp_data,
   output logic                  empty,
   input  logic                  pop,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   op_item_type op_item;
   logic        op_valid, op_pop;

   // limit registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IDLE_FLIP:  cfg_in.idle_flip_ticks  = csr_wdata;
            CSR_DISCONNECT: cfg_in.disconnect_ticks = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_flip_ticks  <= IDLE_FLIP_RESET;
         cfg_ff.disconnect_ticks <= DISCONNECT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   plcr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .full     (full),
      .op_item  (op_item),
      .op_valid (op_valid),
      .op_pop   (op_pop)
   );

   plcr_back #(
      .CARD_BITS (CARD_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .op_item  (op_item),
      .op_valid (op_valid),
      .op_pop   (op_pop),
      .rsp_data (rsp_data),
      .empty    (empty),
      .pop      (pop)
   );

endmodule

>>> tb/pad_link_command_responder_unit_tb.sv
`timescale 1ns / 1ps

module pad_link_command_responder_unit_tb;
   import plcr_pkg::*;

   // Item kind that the block decodes to nothing
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // Bit fill of a card write sequence
   localparam int FILL_RANDOM = 0;
   localparam int FILL_ONES   = 1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   req_type               req_data = '0;
   logic                  full;
   rsp_type               rsp_data;
   logic                  empty;
   logic                  pop = 1'b0;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pad_link_command_responder_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .full      (full),
      .rsp_data  (rsp_data),
      .empty     (empty),
      .pop       (pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Beats waiting to be sent and replies waiting to come back
   req_type pending_beats[$];
   rsp_type expected_replies[$];
   int      beats_queued = 0;
   int      fault_count = 0;

   // Shadow of the responder state and limit registers
   logic [7:0] idle_limit = IDLE_FLIP_RESET;
   logic [7:0] drop_limit = DISCONNECT_RESET;
   logic       console_a = 1'b1;
   link_type   link_now = LINK_IDLE;
   link_type   link_seen = LINK_IDLE;
   logic [7:0] watch_ticks = 8'd0;
   logic [7:0] card_crc = CRC_SEED;
   logic [7:0] crc_term_q = CRC_TERM0;
   int         card_pos = 0;
   logic       card_armed = 1'b0;

   // Work out the reply to one beat and advance the shadow state
   function automatic rsp_type respond(input req_type it);
      rsp_type r;
      r = '0;
      case (it.command)
         KIND_CMD: begin
            case (it.cmd_byte)
               CMD_ORIGIN_A, CMD_ORIGIN_B: r.reply = REPLY_ORIGIN;
               CMD_POLL_B: begin
                  watch_ticks = 8'd0;
                  link_now = LINK_B;
                  r.reply = REPLY_POLL_B;
               end
               CMD_POLL_A: begin
                  watch_ticks = 8'd0;
                  link_now = LINK_A;
                  r.reply = REPLY_POLL_A;
               end
               CMD_CARD_READ: r.reply = REPLY_CARD_READ;
               CMD_CARD_WRITE: begin
                  card_crc = CRC_SEED;
                  crc_term_q = CRC_TERM0;
                  card_pos = 0;
                  card_armed = 1'b1;
               end
               default: r.reply = console_a ? REPLY_STATUS_A : REPLY_STATUS_B;
            endcase
         end
         KIND_DATA: begin
            // term for the next position is the current one stepped once
            if (card_armed) begin
               if (it.data_bit)
                  card_crc = card_crc ^ crc_term_q;
               crc_term_q = (crc_term_q >> 1) ^ (crc_term_q[0] ? CRC_POLY : 8'h00);
               card_pos++;
               if (card_pos == CARD_BITS_DEF) begin
                  r.reply = REPLY_CARD_CRC;
                  r.crc_value = card_crc;
                  card_armed = 1'b0;
                  card_pos = 0;
               end
            end
         end
         KIND_TICK: begin
            if (watch_ticks != 8'hFF)
               watch_ticks++;
            if (link_now != link_seen) begin
               watch_ticks = 8'd0;
               if (link_now == LINK_B)
                  r.event_res = EVENT_DETECT_B;
               else if (link_now == LINK_A)
                  r.event_res = EVENT_DETECT_A;
               link_seen = link_now;
            end
            // a zero limit behaves as one
            if (link_seen == LINK_IDLE) begin
               if (watch_ticks >= ((idle_limit == 8'd0) ? 8'd1 : idle_limit)) begin
                  watch_ticks = 8'd0;
                  console_a = ~console_a;
                  r.event_res = EVENT_FLIP;
               end
            end else if (watch_ticks >= ((drop_limit == 8'd0) ? 8'd1 : drop_limit)) begin
               watch_ticks = 8'd0;
               r.event_res = EVENT_DISCONNECT;
            end
         end
         default: ;
      endcase
      r.mode_a_enabled = console_a;
      return r;
   endfunction

   // Stimulus building
   task automatic add_beat(input logic [1:0] kind, input logic [7:0] cmd, input logic bit_v);
      req_type it;
      it.command = kind;
      it.cmd_byte = cmd;
      it.data_bit = bit_v;
      pending_beats.push_back(it);
      beats_queued++;
   endtask

   task automatic add_cmd(input logic [7:0] cmd);
      add_beat(KIND_CMD, cmd, 1'($urandom_range(0, 1)));
   endtask

   task automatic add_bit(input logic bit_v);
      add_beat(KIND_DATA, 8'($urandom_range(0, 255)), bit_v);
   endtask

   task automatic add_tick();
      add_beat(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic add_spare();
      add_beat(KIND_SPARE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // Random command byte, optionally keeping polls or the card write out
   function automatic logic [7:0] pick_cmd(input bit no_poll, input bit no_arm);
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while ((no_poll && (b == CMD_POLL_A || b == CMD_POLL_B)) ||
             (no_arm && b == CMD_CARD_WRITE));
      return b;
   endfunction

   // Card write: arm, then a full block of bits with stray traffic mixed in
   task automatic card_write(input int fill);
      int k;
      if ($urandom_range(0, 3) == 0) begin
         // partial block that the second arm throws away
         add_cmd(CMD_CARD_WRITE);
         repeat ($urandom_range(1, 30)) add_bit(1'($urandom_range(0, 1)));
      end
      add_cmd(CMD_CARD_WRITE);
      for (k = 0; k < CARD_BITS_DEF; k++) begin
         if ($urandom_range(0, 15) == 0) begin
            if ($urandom_range(0, 1) == 1)
               add_tick();
            else
               add_cmd(pick_cmd(1'b0, 1'b1));
         end
         add_bit((fill == FILL_ONES) ? 1'b1 : 1'($urandom_range(0, 1)));
      end
   endtask

   // Random traffic; without polls the link stays idle
   task automatic fill_random(input int count, input bit allow_polls);
      int stop_at;
      int pick;
      stop_at = beats_queued + count;
      while (beats_queued < stop_at) begin
         pick = $urandom_range(0, 99);
         if (!allow_polls) begin
            if (pick < 75)
               add_tick();
            else if (pick < 92)
               add_cmd(pick_cmd(1'b1, 1'b0));
            else if (pick < 96)
               add_bit(1'($urandom_range(0, 1)));
            else
               add_spare();
         end else if (pick < 25) begin
            add_cmd(($urandom_range(0, 1) == 1) ? CMD_POLL_A : CMD_POLL_B);
            repeat ($urandom_range(0, 12)) add_tick();
         end else if (pick < 55) begin
            repeat ($urandom_range(1, 20)) add_tick();
         end else if (pick < 85) begin
            add_cmd(8'($urandom_range(0, 255)));
         end else if (pick < 93) begin
            add_bit(1'($urandom_range(0, 1)));
         end else begin
            add_spare();
         end
      end
   endtask

   // Wait until every beat is sent and answered, then let the pipe empty
   task automatic drain_and_settle();
      while (pending_beats.size() != 0 || req_push || expected_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_IDLE_FLIP)
         idle_limit = val;
      else
         drop_limit = val;
   endtask

   // Sender: bursts of random length separated by random gaps
   int burst_left = 8;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !full) begin
            expected_replies.push_back(respond(req_data));
            void'(pending_beats.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            end
         end
         // a beat refused by a full queue stays on the port unchanged
         if (!(req_push && full)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (pending_beats.size() != 0) begin
               req_push <= 1'b1;
               req_data <= pending_beats[0];
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Receiver: pop follows a rotating stall pattern, renewed when its age counter wraps
   logic [15:0] pop_pattern = 16'hFFFF;
   int          pattern_age = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_replies.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("%0t: reply beat with nothing outstanding: %h", $time, rsp_data);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_data.reply !== want.reply ||
                   rsp_data.crc_value !== want.crc_value ||
                   rsp_data.event_res !== want.event_res ||
                   rsp_data.mode_a_enabled !== want.mode_a_enabled) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display("%0t: reply exp %0d/%h/%0d/%0b got %0d/%h/%0d/%0b", $time,
                              want.reply, want.crc_value, want.event_res,
                              want.mode_a_enabled, rsp_data.reply, rsp_data.crc_value,
                              rsp_data.event_res, rsp_data.mode_a_enabled);
               end
            end
         end
         if (pattern_age == 63) begin
            pattern_age = 0;
            pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'h0001);
         end else begin
            pattern_age++;
         end
         pop <= pop_pattern[0];
         pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
      end
   end

   // Watchdog on cycles with no beat moving on either side
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Idle link at reset limits: status, origin, card read, ignored beats,
      // commands while a card write is armed, restart of the card write
      add_cmd(8'h00);
      add_cmd(8'hFF);
      add_cmd(8'h80);
      add_cmd(CMD_ORIGIN_A);
      add_cmd(CMD_ORIGIN_B);
      add_cmd(CMD_CARD_READ);
      add_bit(1'b0);
      add_bit(1'b1);
      add_beat(KIND_SPARE, 8'hFF, 1'b1);
      add_beat(KIND_SPARE, 8'h00, 1'b0);
      add_tick();
      add_cmd(CMD_CARD_WRITE);
      add_bit(1'b1);
      add_cmd(8'h7F);
      add_bit(1'b0);
      add_cmd(CMD_CARD_WRITE);
      fill_random(80, 1'b0);
      drain_and_settle();

      // Zero idle limit: every idle tick flips the console mode
      write_limit(CSR_IDLE_FLIP, 8'd0);
      fill_random(40, 1'b0);
      drain_and_settle();

      // Longest idle limit, reached by a long tick run
      write_limit(CSR_IDLE_FLIP, 8'd255);
      fill_random(40, 1'b0);
      repeat (230) add_tick();
      drain_and_settle();

      // Polls start here; the link never returns to idle
      write_limit(CSR_IDLE_FLIP, 8'd1);
      write_limit(CSR_DISCONNECT, 8'd1);
      add_cmd(CMD_POLL_B);
      add_tick();
      add_tick();
      add_cmd(CMD_POLL_A);
      add_tick();
      add_tick();
      card_write(FILL_RANDOM);
      fill_random(20, 1'b1);
      drain_and_settle();

      write_limit(CSR_DISCONNECT, 8'd0);
      fill_random(40, 1'b1);
      drain_and_settle();

      // Longest disconnect limit
      write_limit(CSR_DISCONNECT, 8'd255);
      add_cmd(CMD_POLL_A);
      repeat (256) add_tick();
      fill_random(30, 1'b1);
      drain_and_settle();

      write_limit(CSR_DISCONNECT, 8'($urandom_range(2, 60)));
      write_limit(CSR_IDLE_FLIP, 8'($urandom_range(1, 255)));
      card_write(FILL_ONES);
      fill_random(40, 1'b1);
      drain_and_settle();

      if (fault_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/plcr_pkg.sv
design/plcr_fifo.sv
design/plcr_front.sv
design/plcr_back.sv
design/pad_link_command_responder_unit.sv
tb/pad_link_command_responder_unit_tb.sv
